[sv/aprep_pkg.sv]
// ----------------------------------------------------------------------------
// aprep_pkg
// Shared types and constants for the aging page-replacement core.
// ----------------------------------------------------------------------------
package aprep_pkg;

    localparam int FRAMES_DEF   = 16;
    localparam int AGE_BITS_DEF = 8;
    localparam int PAGE_BITS    = 16;
    localparam int CFG_BITS     = 5;
    localparam int CFG_RESET    = 16;
    localparam int COUNT_BITS   = 32;
    localparam int FIDX_BITS    = 4;
    localparam int IN_BYTES_W   = 16;
    localparam int OUT_BYTES_W  = 88;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_AGE,
        ST_AGE_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic sample;
        logic valid;
    } scan_ctrl_t;

    typedef struct packed {
        logic hit_found;
        logic empty_found;
    } scan_flags_t;

endpackage

[sv/aprep_ram.sv]
// ----------------------------------------------------------------------------
// aprep_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module aprep_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/aprep_scan.sv]
// ----------------------------------------------------------------------------
// aprep_scan
// Shared compare unit: tracks first match, first empty frame and oldest frame
// as frames stream out of the frame memory one per cycle.
// ----------------------------------------------------------------------------
module aprep_scan #(
    parameter int FRAMES   = aprep_pkg::FRAMES_DEF,
    parameter int AGE_BITS = aprep_pkg::AGE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  aprep_pkg::scan_ctrl_t          ctrl,
    input  logic [$clog2(FRAMES)-1:0]      idx,
    input  logic [aprep_pkg::PAGE_BITS-1:0] page_req,
    input  logic [aprep_pkg::PAGE_BITS-1:0] page_rd,
    input  logic [AGE_BITS-1:0]            age_rd,
    output aprep_pkg::scan_flags_t         flags,
    output logic [$clog2(FRAMES)-1:0]      hit_idx,
    output logic [$clog2(FRAMES)-1:0]      empty_idx,
    output logic [$clog2(FRAMES)-1:0]      min_idx,
    output logic [aprep_pkg::PAGE_BITS-1:0] min_page
);

    localparam int IDX_W = $clog2(FRAMES);

    aprep_pkg::scan_flags_t              flags_reg, flags_next;
    logic                                min_vld_reg, min_vld_next;
    logic [IDX_W-1:0]                    hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]                    empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]                    min_idx_reg, min_idx_next;
    logic [AGE_BITS-1:0]                 min_age_reg, min_age_next;
    logic [aprep_pkg::PAGE_BITS-1:0]     min_page_reg, min_page_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg   <= '0;
            min_vld_reg <= 1'b0;
        end
        else
        begin
            flags_reg   <= flags_next;
            min_vld_reg <= min_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg   <= hit_idx_next;
        empty_idx_reg <= empty_idx_next;
        min_idx_reg   <= min_idx_next;
        min_age_reg   <= min_age_next;
        min_page_reg  <= min_page_next;
    end

    always_comb
    begin
        flags_next     = flags_reg;
        min_vld_next   = min_vld_reg;
        hit_idx_next   = hit_idx_reg;
        empty_idx_next = empty_idx_reg;
        min_idx_next   = min_idx_reg;
        min_age_next   = min_age_reg;
        min_page_next  = min_page_reg;
        if (ctrl.clear)
        begin
            flags_next   = '0;
            min_vld_next = 1'b0;
        end
        else if (ctrl.sample)
        begin
            if (!flags_reg.hit_found && ctrl.valid && (page_rd == page_req))
            begin
                flags_next.hit_found = 1'b1;
                hit_idx_next         = idx;
            end
            if (!flags_reg.empty_found && !ctrl.valid)
            begin
                flags_next.empty_found = 1'b1;
                empty_idx_next         = idx;
            end
            // strict less-than keeps the lowest index on ties
            if (!min_vld_reg || (age_rd < min_age_reg))
            begin
                min_vld_next  = 1'b1;
                min_idx_next  = idx;
                min_age_next  = age_rd;
                min_page_next = page_rd;
            end
        end
    end

    assign flags     = flags_reg;
    assign hit_idx   = hit_idx_reg;
    assign empty_idx = empty_idx_reg;
    assign min_idx   = min_idx_reg;
    assign min_page  = min_page_reg;

endmodule

[sv/aging_page_replacement_core.sv]
// ----------------------------------------------------------------------------
// aging_page_replacement_core
// Aging page-replacement table with one request and one result per item.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A request holds the block from acceptance
// through the scan sweep, the decision and the aging sweep until its result
// register is loaded, later if the previous result is still waiting there.
// Page and age for all frames sit in one frame memory with one read port,
// while the resident bits are flops; the memory is swept once to find a match,
// the first empty frame and the oldest frame, then swept again to write back
// the aged entries. s_tready is high only between requests; one finished
// result can wait in the output register while the next request is taken.
// frames_in_use is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while no request is in flight, as the block does not enforce
// this. 0 acts as 1 and values above FRAMES act as FRAMES.
module aging_page_replacement_core #(
    parameter int FRAMES   = aprep_pkg::FRAMES_DEF,
    parameter int AGE_BITS = aprep_pkg::AGE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [aprep_pkg::CFG_BITS-1:0]      cfg_wr_data,  // frames_in_use
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [aprep_pkg::IN_BYTES_W-1:0]    s_tdata,      // page_number
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit, frame_index, evicted_valid, evicted_page, hit_total, miss_total
    output logic [aprep_pkg::OUT_BYTES_W-1:0]   m_tdata
);

    localparam int IDX_W  = $clog2(FRAMES);
    localparam int PG_W   = aprep_pkg::PAGE_BITS;
    localparam int CNT_W  = aprep_pkg::COUNT_BITS;
    localparam int ENT_W  = PG_W + AGE_BITS;
    localparam int FIDX_W = aprep_pkg::FIDX_BITS;

    aprep_pkg::state_t      state_reg, state_next;
    logic [aprep_pkg::CFG_BITS-1:0] cfg_reg;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0]       last_reg, last_next;
    logic [PG_W-1:0]        page_reg, page_next;
    logic                   samp_vld_reg, samp_vld_next;
    logic                   samp_age_reg, samp_age_next;
    logic [IDX_W-1:0]       samp_idx_reg, samp_idx_next;
    logic [FRAMES-1:0]      valid_reg, valid_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic                   hit_reg, hit_next;
    logic                   ev_vld_reg, ev_vld_next;
    logic [PG_W-1:0]        ev_page_reg, ev_page_next;
    logic [CNT_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]       miss_cnt_reg, miss_cnt_next;
    logic                   out_vld_reg, out_vld_next;
    logic [aprep_pkg::OUT_BYTES_W-1:0] out_data_reg, out_data_next;

    logic [31:0]            eff_m1;
    logic [ENT_W-1:0]       rd_data;
    logic [ENT_W-1:0]       wr_data;
    logic                   ram_we;
    logic [PG_W-1:0]        rd_page;
    logic [AGE_BITS-1:0]    rd_age;
    logic [AGE_BITS-1:0]    new_age;
    logic [PG_W-1:0]        new_page;
    logic                   is_slot;
    logic [IDX_W+FIDX_W-1:0] slot_ext;

    aprep_pkg::scan_ctrl_t  scan_ctrl;
    aprep_pkg::scan_flags_t scan_flags;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       empty_idx;
    logic [IDX_W-1:0]       min_idx;
    logic [PG_W-1:0]        min_page;

    assign rd_page = rd_data[ENT_W-1:AGE_BITS];
    assign rd_age  = rd_data[AGE_BITS-1:0];

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            eff_m1 = 32'd0;
        end
        else if (32'(cfg_reg) > 32'(FRAMES))
        begin
            eff_m1 = 32'(FRAMES - 1);
        end
        else
        begin
            eff_m1 = 32'(cfg_reg) - 32'd1;
        end
    end

    aprep_ram #(
        .WIDTH (ENT_W),
        .DEPTH (FRAMES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (samp_idx_reg),
        .wdata (wr_data),
        .raddr (cnt_reg),
        .rdata (rd_data)
    );

    assign scan_ctrl.clear  = (state_reg == aprep_pkg::ST_IDLE);
    assign scan_ctrl.sample = samp_vld_reg && !samp_age_reg;
    assign scan_ctrl.valid  = valid_reg[samp_idx_reg];

    aprep_scan #(
        .FRAMES   (FRAMES),
        .AGE_BITS (AGE_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .idx       (samp_idx_reg),
        .page_req  (page_reg),
        .page_rd   (rd_page),
        .age_rd    (rd_age),
        .flags     (scan_flags),
        .hit_idx   (hit_idx),
        .empty_idx (empty_idx),
        .min_idx   (min_idx),
        .min_page  (min_page)
    );

    // aging write-back
    assign is_slot = (samp_idx_reg == slot_reg);
    assign ram_we  = samp_vld_reg && samp_age_reg;

    always_comb
    begin
        new_age  = {1'b0, rd_age[AGE_BITS-1:1]};
        new_page = rd_page;
        if (is_slot)
        begin
            if (hit_reg)
            begin
                new_age = {1'b1, rd_age[AGE_BITS-1:1]};
            end
            else
            begin
                new_age  = {1'b1, {(AGE_BITS-1){1'b0}}};
                new_page = page_reg;
            end
        end
        wr_data = {new_page, new_age};
    end

    assign slot_ext = {{FIDX_W{1'b0}}, slot_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= aprep_pkg::ST_IDLE;
            cfg_reg      <= aprep_pkg::CFG_BITS'(aprep_pkg::CFG_RESET);
            cnt_reg      <= '0;
            samp_vld_reg <= 1'b0;
            samp_age_reg <= 1'b0;
            valid_reg    <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            cnt_reg      <= cnt_next;
            samp_vld_reg <= samp_vld_next;
            samp_age_reg <= samp_age_next;
            valid_reg    <= valid_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        page_reg     <= page_next;
        samp_idx_reg <= samp_idx_next;
        slot_reg     <= slot_next;
        hit_reg      <= hit_next;
        ev_vld_reg   <= ev_vld_next;
        ev_page_reg  <= ev_page_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        page_next     = page_reg;
        samp_vld_next = 1'b0;
        samp_age_next = samp_age_reg;
        samp_idx_next = cnt_reg;
        valid_next    = valid_reg;
        slot_next     = slot_reg;
        hit_next      = hit_reg;
        ev_vld_next   = ev_vld_reg;
        ev_page_next  = ev_page_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_data_next = out_data_reg;
        s_tready      = 1'b0;

        unique case (state_reg)
            aprep_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cnt_next = '0;
                if (s_tvalid)
                begin
                    page_next  = s_tdata[PG_W-1:0];
                    last_next  = eff_m1[IDX_W-1:0];
                    state_next = aprep_pkg::ST_SCAN;
                end
            end
            aprep_pkg::ST_SCAN:
            begin
                samp_vld_next = 1'b1;
                samp_age_next = 1'b0;
                if (cnt_reg == last_reg)
                begin
                    state_next = aprep_pkg::ST_SCAN_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            aprep_pkg::ST_SCAN_END:
            begin
                state_next = aprep_pkg::ST_DECIDE;
            end
            aprep_pkg::ST_DECIDE:
            begin
                cnt_next     = '0;
                ev_vld_next  = 1'b0;
                ev_page_next = '0;
                hit_next     = scan_flags.hit_found;
                if (scan_flags.hit_found)
                begin
                    slot_next = hit_idx;
                    if (hit_cnt_reg != '1)
                    begin
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    if (scan_flags.empty_found)
                    begin
                        slot_next = empty_idx;
                    end
                    else
                    begin
                        slot_next    = min_idx;
                        ev_vld_next  = 1'b1;
                        ev_page_next = min_page;
                    end
                    valid_next[slot_next] = 1'b1;
                    if (miss_cnt_reg != '1)
                    begin
                        miss_cnt_next = miss_cnt_reg + 1'b1;
                    end
                end
                state_next = aprep_pkg::ST_AGE;
            end
            aprep_pkg::ST_AGE:
            begin
                samp_vld_next = 1'b1;
                samp_age_next = 1'b1;
                if (cnt_reg == last_reg)
                begin
                    state_next = aprep_pkg::ST_AGE_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            aprep_pkg::ST_AGE_END:
            begin
                state_next = aprep_pkg::ST_DONE;
            end
            aprep_pkg::ST_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = {2'b00, miss_cnt_reg, hit_cnt_reg, ev_page_reg,
                                     ev_vld_reg, slot_ext[FIDX_W-1:0], hit_reg};
                    state_next    = aprep_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aprep_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one still in flight");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aprep_pkg::ST_DONE) && hit_reg |-> !ev_vld_reg)
        else $error("eviction reported on a hit");

    a_write_in_age: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == aprep_pkg::ST_AGE) || (state_reg == aprep_pkg::ST_AGE_END))
        else $error("frame memory written outside the aging sweep");

    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aprep_pkg::ST_DECIDE) |=>
            ((hit_cnt_reg != $past(hit_cnt_reg)) + (miss_cnt_reg != $past(miss_cnt_reg))) <= 1)
        else $error("both counters moved on one request");

    a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aprep_pkg::ST_AGE) |-> valid_reg[slot_reg])
        else $error("chosen frame not marked resident");

endmodule
